// ===== hdl/hes_pkg.sv =====
// Package for the haptic envelope sequencer: command, event and state types.
// Used by hes_front, hes_divider, hes_engine and the top level.
package hes_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;
    localparam int DIV_STEPS   = 16;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_PLAY     = 2'd1,
        FUNC_LOAD_EV  = 2'd2,
        FUNC_LOAD_SEQ = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEQ_RD,
        ST_EV_RD,
        ST_EV_CHK,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] delay;
        logic        motor;
        logic [15:0] gate;
        logic [15:0] level;
    } ev_t;

    typedef struct packed {
        func_t       func;
        logic [1:0]  pad;
        logic [15:0] elapsed;
        logic [1:0]  seq_select;
        logic [3:0]  entry_addr;
        ev_t         ev;
        logic [3:0]  seq_first;
        logic [4:0]  seq_count;
    } cmd_t;

endpackage

// ===== hdl/hes_front.sv =====
// Front end: accepts input beats, decodes them into commands, and queues them.
// Depends on hes_pkg.
module hes_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hes_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic [1:0]                     s_tuser,
    output logic                           cmd_valid,
    input  logic                           cmd_pop,
    output hes_pkg::cmd_t                  cmd
);
    import hes_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec;
    logic       push;

    // field decode
    always_comb
    begin
        dec.func       = func_t'(s_tuser);
        dec.pad        = s_tdata[1:0];
        dec.elapsed    = s_tdata[17:2];
        dec.seq_select = s_tdata[19:18];
        dec.entry_addr = s_tdata[23:20];
        dec.ev.delay   = s_tdata[39:24];
        dec.ev.motor   = s_tdata[40];
        dec.ev.gate    = s_tdata[56:41];
        dec.ev.level   = s_tdata[72:57];
        dec.seq_first  = s_tdata[76:73];
        dec.seq_count  = s_tdata[81:77];
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// ===== hdl/hes_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, quotient saturated at 16 bits.
// Depends on hes_pkg.
module hes_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [35:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);
    import hes_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] lo_reg;
    logic [15:0] q_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic        fits;

    assign trial    = {rem_reg, lo_reg[15]};
    assign fits     = (trial >= {1'b0, divisor});
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            if (dividend[35:16] >= {4'b0, divisor})
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= 5'(DIV_STEPS);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[31:16];
            lo_reg  <= dividend[15:0];
            q_reg   <= 16'hFFFF;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
            q_reg   <= {q_reg[14:0], fits};
            lo_reg  <= {lo_reg[14:0], 1'b0};
        end
    end

endmodule

// ===== hdl/hes_engine.sv =====
// Back end: event and sequence stores, pad and motor state, tick sequencer, result register.
// Depends on hes_pkg and hes_divider.
module hes_engine #(
    parameter int NUM_PADS    = 4,
    parameter int EVENT_DEPTH = 16,
    parameter int SEQ_DEPTH   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [2:0]                      num_sequences,
    input  logic                            cmd_valid,
    input  hes_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hes_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hes_pkg::*;

    localparam int PADW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int SAW  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int EA_W = $clog2(EVENT_DEPTH);
    localparam int PW   = $clog2(EVENT_DEPTH + 1);
    localparam int SUMW = EA_W + 6;

    // stores (undefined until written)
    ev_t             ev_mem [EVENT_DEPTH];
    logic [EA_W-1:0] seq_first_mem [SEQ_DEPTH];
    logic [PW-1:0]   seq_cnt_mem [SEQ_DEPTH];
    ev_t             ev_rd_reg;
    logic [EA_W-1:0] seq_first_rd_reg;
    logic [PW-1:0]   seq_cnt_rd_reg;

    // per-pad and per-motor state, motor arrays indexed [motor][pad]
    logic            pad_active_reg [NUM_PADS];
    logic [1:0]      pad_seq_reg [NUM_PADS];
    logic [PW-1:0]   pad_pos_reg [NUM_PADS];
    logic [15:0]     pad_acc_reg [NUM_PADS];
    logic [15:0]     mot_elapsed_reg [2][NUM_PADS];
    logic [15:0]     mot_gate_reg [2][NUM_PADS];
    logic [15:0]     mot_start_reg [2][NUM_PADS];
    logic [15:0]     mot_target_reg [2][NUM_PADS];

    state_t          state_reg, state_next;
    cmd_t            cmd_reg;
    logic [EA_W-1:0] first_reg;
    logic [PW-1:0]   cnt_reg;
    logic [PW-1:0]   pos_reg;
    logic [15:0]     acc_reg;
    logic            msel_reg;
    logic [31:0]     p1_reg;
    logic [33:0]     p2_reg;
    logic [15:0]     den_reg;
    logic [31:0]     num_reg;
    logic [15:0]     spd_low_reg, spd_high_reg;
    logic            out_valid_reg;
    logic [1:0]      out_pad_reg;
    logic [15:0]     out_low_reg, out_high_reg;

    // decode and datapath
    logic [PADW-1:0] q_pad_idx, pad_idx;
    logic            q_pad_ok;
    logic [SAW-1:0]  seq_raddr;
    logic [SUMW-1:0] first_red;
    logic [PW-1:0]   cnt_clamped;
    logic [SUMW-1:0] ev_sum;
    logic [EA_W-1:0] ev_raddr;
    logic            pos_lt_cnt;
    logic            ev_due;
    logic [16:0]     acc_sum;
    logic [15:0]     acc_sat;
    logic [15:0]     e_cur, g_cur, st_cur, tg_cur;
    logic [16:0]     e_sum;
    logic            ramp;
    logic signed [16:0] lvl_diff;
    logic signed [33:0] lvl_prod;
    logic signed [34:0] num_sum;
    logic [47:0]     scaled;
    logic            out_free;

    // control decode
    logic            ev_we, seq_we, play_go, tick_go, wb_pad, apply_ev, div_start;
    logic            div_done;
    logic [15:0]     div_q;

    assign q_pad_idx  = PADW'(cmd.pad);
    assign q_pad_ok   = (32'(cmd.pad) < NUM_PADS);
    assign pad_idx    = PADW'(cmd_reg.pad);
    assign seq_raddr  = SAW'(pad_seq_reg[q_pad_idx]);
    assign pos_lt_cnt = (pos_reg < cnt_reg);
    assign ev_due     = (acc_reg >= ev_rd_reg.delay);
    assign out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        first_red = SUMW'(cmd.seq_first);
        for (int i = 0; i < 3; i++)
        begin
            if (first_red >= SUMW'(EVENT_DEPTH))
            begin
                first_red = first_red - SUMW'(EVENT_DEPTH);
            end
        end
        cnt_clamped = (32'(cmd.seq_count) > EVENT_DEPTH) ? PW'(EVENT_DEPTH)
                                                          : PW'(cmd.seq_count);
    end

    // event address wraps once at most: first < depth, position < count <= depth
    always_comb
    begin
        ev_sum = SUMW'(first_reg) + SUMW'(pos_reg);
        if (ev_sum >= SUMW'(EVENT_DEPTH))
        begin
            ev_sum = ev_sum - SUMW'(EVENT_DEPTH);
        end
        ev_raddr = EA_W'(ev_sum);
    end

    always_comb
    begin
        acc_sum = {1'b0, pad_acc_reg[pad_idx]} + {1'b0, cmd_reg.elapsed};
        acc_sat = acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
    end

    always_comb
    begin
        e_cur    = mot_elapsed_reg[msel_reg][pad_idx];
        g_cur    = mot_gate_reg[msel_reg][pad_idx];
        st_cur   = mot_start_reg[msel_reg][pad_idx];
        tg_cur   = mot_target_reg[msel_reg][pad_idx];
        e_sum    = {1'b0, e_cur} + {1'b0, cmd_reg.elapsed};
        ramp     = (e_sum < {1'b0, g_cur});
        lvl_diff = $signed({1'b0, tg_cur}) - $signed({1'b0, st_cur});
        lvl_prod = lvl_diff * $signed({1'b0, e_sum[15:0]});
        num_sum  = $signed({3'b0, p1_reg}) + $signed({p2_reg[33], p2_reg});
        scaled   = {num_reg, 16'b0} - {16'b0, num_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.func == FUNC_TICK) && q_pad_ok)
                begin
                    state_next = pad_active_reg[q_pad_idx] ? ST_SEQ_RD : ST_EMIT;
                end
            end
            ST_SEQ_RD: state_next = ST_EV_RD;
            ST_EV_RD:  state_next = pos_lt_cnt ? ST_EV_CHK : ST_MUL;
            ST_EV_CHK: state_next = ev_due ? ST_EV_RD : ST_MUL;
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = msel_reg ? ST_EMIT : ST_MUL;
                end
            end
            ST_EMIT:   state_next = out_free ? ST_IDLE : ST_EMIT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_pop   = 1'b0;
        ev_we     = 1'b0;
        seq_we    = 1'b0;
        play_go   = 1'b0;
        tick_go   = 1'b0;
        wb_pad    = 1'b0;
        apply_ev  = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                if (cmd_valid)
                begin
                    unique case (cmd.func)
                        FUNC_LOAD_EV:  ev_we  = (32'(cmd.entry_addr) < EVENT_DEPTH);
                        FUNC_LOAD_SEQ: seq_we = (32'(cmd.seq_select) < SEQ_DEPTH);
                        FUNC_PLAY:     play_go = q_pad_ok
                                           && ({1'b0, cmd.seq_select} < num_sequences)
                                           && (32'(cmd.seq_select) < SEQ_DEPTH);
                        FUNC_TICK:     tick_go = q_pad_ok;
                        default:       ;
                    endcase
                end
            end
            ST_EV_RD:  wb_pad = !pos_lt_cnt;
            ST_EV_CHK:
            begin
                apply_ev = ev_due;
                wb_pad   = !ev_due;
            end
            ST_SCALE:  div_start = 1'b1;
            default:   ;
        endcase
    end

    hes_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled[47:12]),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // stores, registered read
    always_ff @(posedge clk)
    begin
        if (ev_we)
        begin
            ev_mem[EA_W'(cmd.entry_addr)] <= cmd.ev;
        end
        ev_rd_reg <= ev_mem[ev_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seq_we)
        begin
            seq_first_mem[SAW'(cmd.seq_select)] <= EA_W'(first_red);
            seq_cnt_mem[SAW'(cmd.seq_select)]   <= cnt_clamped;
        end
        seq_first_rd_reg <= seq_first_mem[seq_raddr];
        seq_cnt_rd_reg   <= seq_cnt_mem[seq_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            msel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int p = 0; p < NUM_PADS; p++)
            begin
                pad_active_reg[p] <= 1'b0;
                pad_seq_reg[p]    <= 2'd0;
                pad_pos_reg[p]    <= '0;
                pad_acc_reg[p]    <= 16'd0;
                for (int m = 0; m < 2; m++)
                begin
                    mot_elapsed_reg[m][p] <= 16'd0;
                    mot_gate_reg[m][p]    <= 16'd0;
                    mot_start_reg[m][p]   <= 16'd0;
                    mot_target_reg[m][p]  <= 16'd0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (play_go)
            begin
                pad_active_reg[q_pad_idx] <= 1'b1;
                pad_seq_reg[q_pad_idx]    <= cmd.seq_select;
                pad_pos_reg[q_pad_idx]    <= '0;
                pad_acc_reg[q_pad_idx]    <= 16'd0;
            end
            if (wb_pad)
            begin
                pad_pos_reg[pad_idx] <= pos_reg;
                pad_acc_reg[pad_idx] <= acc_reg;
            end
            if (apply_ev)
            begin
                mot_elapsed_reg[ev_rd_reg.motor][pad_idx] <= 16'd0;
                mot_gate_reg[ev_rd_reg.motor][pad_idx]    <= ev_rd_reg.gate;
                mot_start_reg[ev_rd_reg.motor][pad_idx]   <=
                    mot_target_reg[ev_rd_reg.motor][pad_idx];
                mot_target_reg[ev_rd_reg.motor][pad_idx]  <= ev_rd_reg.level;
            end
            if ((state_reg == ST_MUL) && ramp)
            begin
                mot_elapsed_reg[msel_reg][pad_idx] <= e_sum[15:0];
            end
            if (tick_go)
            begin
                msel_reg <= 1'b0;
            end
            else if ((state_reg == ST_DIV) && div_done)
            begin
                msel_reg <= 1'b1;
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            cmd_reg      <= cmd;
            spd_low_reg  <= 16'd0;
            spd_high_reg <= 16'd0;
        end
        if (state_reg == ST_SEQ_RD)
        begin
            first_reg <= seq_first_rd_reg;
            cnt_reg   <= seq_cnt_rd_reg;
            pos_reg   <= pad_pos_reg[pad_idx];
            acc_reg   <= acc_sat;
        end
        if (apply_ev)
        begin
            acc_reg <= acc_reg - ev_rd_reg.delay;
            pos_reg <= pos_reg + PW'(1);
        end
        if (state_reg == ST_MUL)
        begin
            p1_reg  <= ramp ? (st_cur * g_cur) : {16'd0, tg_cur};
            p2_reg  <= ramp ? lvl_prod : 34'sd0;
            den_reg <= ramp ? g_cur : 16'd1;
        end
        if (state_reg == ST_SUM)
        begin
            num_reg <= num_sum[34] ? 32'd0 : num_sum[31:0];
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            if (msel_reg)
            begin
                spd_high_reg <= div_q;
            end
            else
            begin
                spd_low_reg <= div_q;
            end
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_pad_reg  <= cmd_reg.pad;
            out_low_reg  <= spd_low_reg;
            out_high_reg <= spd_high_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_high_reg, out_low_reg, out_pad_reg};

endmodule

// ===== hdl/haptic_envelope_sequencer.sv =====
// Haptic envelope sequencer top level: front end, command queue and back-end engine.
// Depends on hes_pkg, hes_front, hes_engine.
//
// Two-motor piecewise linear vibration envelope player for up to NUM_PADS pads.
// Each input beat carries a command in s_axis_tuser: tick, play a sequence,
// load an event entry, or load a sequence descriptor. Loads and play take
// effect as the engine takes them and produce no output. A tick advances the
// pad's time, applies every due event of its sequence in order (each one
// starts a linear ramp on its motor from the last target to the event level
// over the event's gate time), then reports both motor speeds, scaled to
// 0..65535 and saturated, as one output beat; an idle pad reports zeros and
// a pad number of NUM_PADS or more gives no beat. Levels and times are unsigned
// Q4.12. Most of a tick's time in the engine is the shared 16-step divider,
// run once per motor. A two-entry queue decouples the input from the engine
// and an output register holds the result, so the input keeps accepting while
// a result waits, until the queue is full. The user must write num_sequences
// through cfg_we / cfg_wdata only while the block is idle; the block does not
// enforce this. Event and descriptor stores are not cleared at reset.
module haptic_envelope_sequencer #(
    parameter int NUM_PADS    = 4,
    parameter int EVENT_DEPTH = 16,
    parameter int SEQ_DEPTH   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_wdata,      // num_sequences
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pad[1:0] elapsed[17:2] seq_select[19:18] entry_addr[23:20] ev_delay[39:24]
    // ev_motor[40] ev_gate[56:41] ev_level[72:57] seq_first[76:73] seq_count[81:77]
    input  logic [hes_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,   // func
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_pad[1:0] low_speed[17:2] high_speed[33:18]
    output logic [hes_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import hes_pkg::*;

    logic [2:0] num_seq_reg;
    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd;

    // sequence count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_seq_reg <= 3'd0;
        end
        else if (cfg_we)
        begin
            num_seq_reg <= cfg_wdata;
        end
    end

    hes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .s_tuser   (s_axis_tuser),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    hes_engine #(
        .NUM_PADS    (NUM_PADS),
        .EVENT_DEPTH (EVENT_DEPTH),
        .SEQ_DEPTH   (SEQ_DEPTH)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_sequences (num_seq_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_tvalid      (m_axis_tvalid),
        .m_tready      (m_axis_tready),
        .m_tdata       (m_axis_tdata)
    );

endmodule

// ===== hdl/hes_checker.sv =====
// Port-level checker for the haptic envelope sequencer, bound to the top level.
// Depends on haptic_envelope_sequencer ports only.
module hes_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[39:34] == 6'd0))
        else $error("result padding bits not zero");

    // at most two result beats back to back: a held beat, then the one queued behind it
    a_no_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && $past(m_axis_tvalid && m_axis_tready))
        |=> !m_axis_tvalid)
        else $error("three result beats in a row");

endmodule

bind haptic_envelope_sequencer hes_checker u_hes_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
